[hdl/hds_pkg.sv]
// Shared types and constants for the Hessian determinant stencil unit.
// Used by hds_kernel, hessian_determinant_stencil_unit and the bench; no dependencies.
package hds_pkg;

   // Field widths of the stream payloads
   localparam int PIX_W        = 16;
   localparam int RESP_W       = 40;
   localparam int ROW_W        = 12;
   localparam int OUT_COL_W    = 11;
   localparam int RSP_TDATA_W  = 64;

   // Configuration registers
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Frame size limits
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int MIN_SIZE      = 3;

   // Arithmetic widths: second differences are held in 19 signed bits,
   // 16*Lxx*Lyy in 42 before truncation to the response
   localparam int LAP_W  = 19;
   localparam int PROD_W = 42;

   // 3x3 window: t/m/b rows, l/c/r columns
   typedef struct packed {
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tc;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] ml;
      logic [PIX_W-1:0] mc;
      logic [PIX_W-1:0] mr;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] bc;
      logic [PIX_W-1:0] br;
   } window_type;

endpackage

[hdl/hessian_determinant_stencil_unit.sv]
// Top level of the 3x3 Hessian determinant stencil over a raster pixel stream.
// Depends on hds_pkg and hds_kernel; holds the two line buffers.
//
//  channel  direction  handshake                payload
//  req_     in         req_tvalid/req_tready    tdata[15:0] pixel
//  rsp_     out        rsp_tvalid/rsp_tready    tdata response,row,col; tlast frame end
//  csr_     in         csr_valid/csr_ready      csr_index, csr_data
//
// One pixel is taken per clock unless rsp_ stalls; each result passes the pixel stage and the result register.
// The line-buffer read is issued as the pixel is taken and registered beside it.
// Border positions give no result. Reset clears counters, window and registers;
// line buffers are not cleared. A stalled rsp_ holds the pixel stage, and
// req_tready drops only while both stages are full and the result is not taken.
module hessian_determinant_stencil_unit
   import hds_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   // pixel stream; tdata: [15:0] pixel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [PIX_W-1:0]        req_tdata,
   // result stream; tdata: [39:0] response, [51:40] out_row, [62:52] out_col,
   // [63] zero; tlast: frame_end
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                    rsp_tlast,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [WIDTH_REG_W-1:0]  width_reg_ff;
   logic [HEIGHT_REG_W-1:0] height_reg_ff;
   logic [EW_W-1:0]         eff_width;
   logic [HEIGHT_REG_W-1:0] eff_height;

   // position of the next incoming pixel
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W:0]   col_plus;
   logic [ROW_W:0]   row_plus;

   // pixel stage
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [PIX_W-1:0] rd_above_ff;
   logic [PIX_W-1:0] rd_middle_ff;
   logic [PIX_W-1:0] win_ff [6];

   // line buffers
   logic [PIX_W-1:0] line_above_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] line_middle_mem [MAX_WIDTH];

   // result stage
   logic                     rsp_valid_ff;
   logic signed [RESP_W-1:0] rsp_response_ff;
   logic [ROW_W-1:0]         rsp_row_ff;
   logic [OUT_COL_W-1:0]     rsp_col_ff;
   logic                     rsp_last_ff;

   logic                     req_accept;
   logic                     advance;
   logic                     emit;
   logic                     frame_last;
   logic [COL_W-1:0]         col_m1;
   window_type               window;
   logic signed [RESP_W-1:0] response;

   // Register port: always ready, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= WIDTH_RESET;
         height_reg_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_reg_ff  <= csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg_ff <= csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp frame size to the supported range
   always_comb begin
      if (width_reg_ff < MIN_SIZE) begin
         eff_width = EW_W'(MIN_SIZE);
      end else if (width_reg_ff > MAX_WIDTH) begin
         eff_width = EW_W'(MAX_WIDTH);
      end else begin
         eff_width = EW_W'(width_reg_ff);
      end
      if (height_reg_ff < MIN_SIZE) begin
         eff_height = HEIGHT_REG_W'(MIN_SIZE);
      end else if (height_reg_ff > HEIGHT_LIMIT) begin
         eff_height = HEIGHT_REG_W'(HEIGHT_LIMIT);
      end else begin
         eff_height = height_reg_ff;
      end
   end

   // Handshake: the pixel stage moves on when the result register is free
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Advance the raster position on each transfer
   assign col_plus = {1'b0, col_count_ff} + 1'b1;
   assign row_plus = {1'b0, row_count_ff} + 1'b1;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (col_plus >= eff_width) begin
            col_count_in = '0;
            row_count_in = (row_plus >= eff_height) ? '0 : row_plus[ROW_W-1:0];
         end else begin
            col_count_in = col_plus[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Pixel stage: hold the pixel and its position
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= col_count_ff;
         s1_row_ff   <= row_count_ff;
      end
   end

   // Line buffers: read at the incoming column, write back as the pixel leaves.
   // Successive columns always differ, so the read never meets the write.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_above_ff <= line_above_mem[col_count_ff];
      end
      if (advance) begin
         line_above_mem[s1_col_ff] <= rd_middle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_middle_ff <= line_middle_mem[col_count_ff];
      end
      if (advance) begin
         line_middle_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   // Window registers: shift centre to left, load the new right column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= rd_above_ff;
         win_ff[1] <= rd_middle_ff;
         win_ff[2] <= s1_pixel_ff;
      end
   end

   assign window.tl = win_ff[3];
   assign window.tc = win_ff[0];
   assign window.tr = rd_above_ff;
   assign window.ml = win_ff[4];
   assign window.mc = win_ff[1];
   assign window.mr = rd_middle_ff;
   assign window.bl = win_ff[5];
   assign window.bc = win_ff[2];
   assign window.br = s1_pixel_ff;

   hds_kernel u_kernel (
      .win      (window),
      .response (response)
   );

   // Interior test and last interior position of the frame
   assign emit = (s1_row_ff >= 2) && (s1_col_ff >= 2)
              && (s1_row_ff < eff_height) && (s1_col_ff < eff_width);
   assign frame_last = (({1'b0, s1_row_ff} + 1'b1) == eff_height)
                    && (({1'b0, s1_col_ff} + 1'b1) == eff_width);
   assign col_m1 = s1_col_ff - 1'b1;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_response_ff <= response;
         rsp_row_ff      <= s1_row_ff - 1'b1;
         rsp_col_ff      <= OUT_COL_W'(col_m1);
         rsp_last_ff     <= frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_col_ff, rsp_row_ff, rsp_response_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks on the stage control
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_count_ff < MAX_WIDTH)
      else $error("column counter beyond line buffer depth");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_tvalid)
      else $error("interior pixel left the stage without a result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("pixel stage moved over a waiting result");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("pixel taken while both stages are held");

endmodule

[hdl/hds_kernel.sv]
// Combinational Hessian determinant kernel over one 3x3 window.
// Depends on hds_pkg for the window type and arithmetic widths.
module hds_kernel
   import hds_pkg::*;
(
   input  window_type                win,
   output logic signed [RESP_W-1:0]  response
);

   logic signed [LAP_W-1:0]    lxx;
   logic signed [LAP_W-1:0]    lyy;
   logic signed [LAP_W-1:0]    lxy4;
   logic signed [2*LAP_W-1:0]  prod_xy;
   logic signed [2*LAP_W-1:0]  prod_cross;
   logic signed [PROD_W-1:0]   diff;

   // Second differences; pixels zero-extended, centre doubled by a shift
   assign lxx  = signed'({3'b000, win.ml}) - signed'({2'b00, win.mc, 1'b0})
               + signed'({3'b000, win.mr});
   assign lyy  = signed'({3'b000, win.tc}) - signed'({2'b00, win.mc, 1'b0})
               + signed'({3'b000, win.bc});
   assign lxy4 = signed'({3'b000, win.tr}) - signed'({3'b000, win.tl})
               + signed'({3'b000, win.bl}) - signed'({3'b000, win.br});

   // Two independent products, then the scaled difference
   assign prod_xy    = lxx * lyy;
   assign prod_cross = lxy4 * lxy4;
   assign diff       = (PROD_W'(prod_xy) <<< 4) - PROD_W'(prod_cross);

   // Keep the low bits, two's complement
   assign response = diff[RESP_W-1:0];

endmodule

[bench/hds_stencil_checker.sv]
// Scoreboard for the Hessian determinant stencil unit: watches the pixel, result and
// register channels, predicts every result and compares it field by field.
// Depends on hds_pkg for field widths, register indexes and size limits.
module hds_stencil_checker
   import hds_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [PIX_W-1:0]        req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    rsp_tlast,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output int                      failures,
   output int                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_LSB = RESP_W;
   localparam int COL_LSB = RESP_W + ROW_W;
   localparam int PAD_LSB = RESP_W + ROW_W + OUT_COL_W;

   typedef struct packed {
      logic [RESP_W-1:0]    response;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 frame_end;
   } hessian_result_type;

   hessian_result_type expected_responses[$];
   int mismatch_count = 0;

   // Own copy of the line buffers, window and position counters
   logic [PIX_W-1:0] row_above_buf  [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] row_middle_buf [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] top_c, mid_c, bot_c, top_l, mid_l, bot_l;
   int unsigned next_col, next_row;
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;

   assign failures = mismatch_count;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Work out the result (if any) that one pixel causes, then shift the window
   task automatic predict_stencil(input logic [PIX_W-1:0] pix);
      int unsigned w, h, c, r, addr;
      logic [PIX_W-1:0] top_r, mid_r;
      longint lxx, lyy, lxy4, det16;
      hessian_result_type res;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      h = clamp_size(height_reg, HEIGHT_LIMIT);
      c = next_col;
      r = next_row;
      addr = c % MAX_WIDTH_DEF;
      top_r = row_above_buf[addr];
      mid_r = row_middle_buf[addr];

      if (r >= 2 && c >= 2 && r < h && c < w) begin
         lxx  = longint'(mid_l) - 2 * longint'(mid_c) + longint'(mid_r);
         lyy  = longint'(top_c) - 2 * longint'(mid_c) + longint'(bot_c);
         lxy4 = longint'(top_r) - longint'(top_l) + longint'(bot_l) - longint'(pix);
         det16 = 16 * lxx * lyy - lxy4 * lxy4;
         res.response  = det16[RESP_W-1:0];
         res.row       = ROW_W'(r - 1);
         res.col       = OUT_COL_W'(c - 1);
         res.frame_end = (r == h - 1) && (c == w - 1);
         expected_responses.push_back(res);
      end

      // shift the window one column and write the line buffers
      top_l = top_c;
      mid_l = mid_c;
      bot_l = bot_c;
      top_c = top_r;
      mid_c = mid_r;
      bot_c = pix;
      row_above_buf[addr]  = mid_r;
      row_middle_buf[addr] = pix;

      // advance the position; a counter beyond a shrunk size wraps here
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   // Compare one result transfer with the oldest expectation
   task automatic check_response();
      hessian_result_type want;
      if (expected_responses.size() == 0) begin
         $error("result transfer with no expectation waiting: tdata %h tlast %b",
                rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         want = expected_responses.pop_front();
         if (rsp_tdata[RESP_W-1:0] !== want.response) begin
            $error("response mismatch: expected %0d, actual %0d",
                   $signed(want.response), $signed(rsp_tdata[RESP_W-1:0]));
            mismatch_count++;
         end
         if (rsp_tdata[ROW_LSB +: ROW_W] !== want.row) begin
            $error("out_row mismatch: expected %0d, actual %0d",
                   want.row, rsp_tdata[ROW_LSB +: ROW_W]);
            mismatch_count++;
         end
         if (rsp_tdata[COL_LSB +: OUT_COL_W] !== want.col) begin
            $error("out_col mismatch: expected %0d, actual %0d",
                   want.col, rsp_tdata[COL_LSB +: OUT_COL_W]);
            mismatch_count++;
         end
         if (rsp_tlast !== want.frame_end) begin
            $error("frame_end mismatch: expected %0d, actual %0d",
                   want.frame_end, rsp_tlast);
            mismatch_count++;
         end
         if (rsp_tdata[RSP_TDATA_W-1:PAD_LSB] !== '0) begin
            $error("tdata pad mismatch: expected 0, actual %0d",
                   rsp_tdata[RSP_TDATA_W-1:PAD_LSB]);
            mismatch_count++;
         end
      end
   endtask

   // Observe transfers; predictions go in before the oldest result is taken out
   always @(posedge clock) begin
      if (reset) begin
         top_c = '0; mid_c = '0; bot_c = '0;
         top_l = '0; mid_l = '0; bot_l = '0;
         next_col = 0;
         next_row = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         expected_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_reg = csr_data[WIDTH_REG_W-1:0];
            else if (csr_index == CSR_IMAGE_HEIGHT)
               height_reg = csr_data[HEIGHT_REG_W-1:0];
         end
         if (req_tvalid && req_tready)
            predict_stencil(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_response();
      end
      outstanding <= expected_responses.size();
   end

endmodule

[bench/tb_hessian_determinant_stencil_unit.sv]
// Top of the regression for hessian_determinant_stencil_unit: clock, reset, pixel
// and register stimulus, random back-pressure and the verdict.
// Depends on hds_pkg, the unit itself and hds_stencil_checker.
module tb_hessian_determinant_stencil_unit
   import hds_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 20;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 440;
   localparam int FILL_WIDTH    = 64;
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   // saddle-free peak: both second differences at their maximum, no cross term
   localparam logic [PIX_W-1:0] PEAK_FRAME [9] = '{
      16'd0,   PIX_MAX, 16'd0,
      PIX_MAX, 16'd0,   PIX_MAX,
      16'd0,   PIX_MAX, 16'd0
   };
   // pure cross term: opposite corners at full scale, all else dark
   localparam logic [PIX_W-1:0] CROSS_FRAME [9] = '{
      16'd0,   16'd0, PIX_MAX,
      16'd0,   16'd0, 16'd0,
      PIX_MAX, 16'd0, 16'd0
   };

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;
   int                      failures;
   int                      outstanding;

   // Stimulus-side view of the frame position and registers
   logic [WIDTH_REG_W-1:0]  width_now  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] height_now = HEIGHT_RESET;
   int unsigned feed_col = 0;
   int unsigned feed_row = 0;
   int unsigned pixels_sent = 0;
   bit tx_burst = 1'b0;

   int stall_left = 0;
   int calm_left  = 0;
   int unsigned rx_roll;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   hessian_determinant_stencil_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   hds_stencil_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Mostly back-to-back, a few short gaps and the odd long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (tx_burst || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return CSR_DATA_W'($urandom_range(0, MIN_SIZE - 1));
      if (roll < 8) return CSR_DATA_W'($urandom_range(MIN_SIZE, 12));
      return CSR_DATA_W'($urandom_range(13, FILL_WIDTH));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return CSR_DATA_W'($urandom_range(0, MIN_SIZE - 1));
      if (roll < 8) return CSR_DATA_W'($urandom_range(MIN_SIZE, 6));
      return CSR_DATA_W'($urandom_range(7, 12));
   endfunction

   // Offer one pixel, hold it until the transfer and track the frame position
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int unsigned gap, w, h;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      w = clamp_size(width_now, MAX_WIDTH_DEF);
      h = clamp_size(height_now, HEIGHT_LIMIT);
      if (feed_col + 1 >= w) begin
         feed_col = 0;
         feed_row = (feed_row + 1 >= h) ? 0 : feed_row + 1;
      end else begin
         feed_col++;
      end
   endtask

   // Random pixels until the position returns to the frame origin
   task automatic send_to_frame_end();
      do send_pixel(PIX_W'($urandom())); while (feed_col != 0 || feed_row != 0);
   endtask

   // Random pixels that stay inside the filled columns of the line buffers
   task automatic send_run(input int unsigned count);
      repeat (count) begin
         if (feed_col + 1 < FILL_WIDTH)
            send_pixel(PIX_W'($urandom()));
      end
   endtask

   // Stop the pixel stream and wait until every expected result is out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only once the block has gone quiet
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_IMAGE_WIDTH)
         width_now = data[WIDTH_REG_W-1:0];
      else if (index == CSR_IMAGE_HEIGHT)
         height_now = data[HEIGHT_REG_W-1:0];
   endtask

   // Result back-pressure: short stalls, rare long ones, and calm stretches
   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rx_roll = $urandom_range(0, 199);
         if (rx_roll == 0)
            calm_left = $urandom_range(50, 300);
         else if (rx_roll < 40)
            stall_left = $urandom_range(1, 3);
         else if (rx_roll < 50)
            stall_left = $urandom_range(4, 12);
         else if (rx_roll < 53)
            stall_left = $urandom_range(20, 50);
      end
   end

   // Watchdog: end the run if no channel moves a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hessian_determinant_stencil_unit regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned first_random, kind, span;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sizes below the minimum clamp to 3x3, extreme pixel patterns,
      // and writes to the unused indexes that must change nothing
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      foreach (PEAK_FRAME[i]) send_pixel(PEAK_FRAME[i]);
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, CSR_DATA_W'(13'h0AAA));
      foreach (CROSS_FRAME[i]) send_pixel(CROSS_FRAME[i]);

      // Fill the first FILL_WIDTH entries of both line buffers; every later
      // run keeps its columns below that, so no result reads an unwritten entry
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(FILL_WIDTH));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(MIN_SIZE));
      send_to_frame_end();

      // Random phases: mostly whole small frames, some broken ones
      first_random = pixels_sent;
      while (pixels_sent - first_random < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // new size, finish the frame under it, often one more whole frame
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
               write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                         CSR_DATA_W'($urandom()));
            if (clamp_size(width_now, MAX_WIDTH_DEF) > FILL_WIDTH ||
                $urandom_range(0, 4) != 0)
               write_csr(CSR_IMAGE_WIDTH, pick_width());
            if (clamp_size(height_now, HEIGHT_LIMIT) > 12 || $urandom_range(0, 4) != 0)
               write_csr(CSR_IMAGE_HEIGHT, pick_height());
            send_to_frame_end();
            if ($urandom_range(0, 1))
               send_to_frame_end();
         end else if (kind < 8) begin
            // cut a frame short
            span = 3 * clamp_size(width_now, MAX_WIDTH_DEF);
            if (span > 40) span = 40;
            send_run($urandom_range(1, span));
         end else if (kind == 8) begin
            // oversized register values in mid-frame, clamped by the block
            if ($urandom_range(0, 1))
               write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(MAX_WIDTH_DEF + 1, 4095)));
            else
               write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(HEIGHT_LIMIT + 1, 8191)));
            send_run($urandom_range(1, 30));
         end else begin
            // hold the stream until every result has come back
            drain_results();
            tx_burst = ~tx_burst;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("hessian_determinant_stencil_unit regression: pass");
      else
         $display("hessian_determinant_stencil_unit regression: fail");
      $finish;
   end

endmodule
